// ===== sv/tcce_pkg.sv =====
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types and constants of the text console character engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

   localparam int OP_W        = 3;
   localparam int CHAR_W      = 8;
   localparam int COLOR_W     = 8;
   localparam int COL_W       = 7;
   localparam int ROW_W       = 5;
   localparam int ENTRY_W     = 16;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 32;
   localparam int RSP_PAD_W   = RSP_TDATA_W - ROW_W - COL_W - ENTRY_W;

   // opcodes
   localparam logic [OP_W-1:0] OP_PUT_CHAR = 3'd0;
   localparam logic [OP_W-1:0] OP_CLEAR    = 3'd1;
   localparam logic [OP_W-1:0] OP_WRITE    = 3'd2;
   localparam logic [OP_W-1:0] OP_COPY     = 3'd3;
   localparam logic [OP_W-1:0] OP_READ     = 3'd4;

   localparam logic [CHAR_W-1:0]  NEWLINE_CHAR = 8'h0A;
   localparam logic [CHAR_W-1:0]  BLANK_CHAR   = 8'h20;
   localparam logic [ENTRY_W-1:0] RESET_ENTRY  = 16'h0720;
   localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h07;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_SCROLL_PRIME,
      ST_SCROLL,
      ST_FILL,
      ST_COPY_WR,
      ST_READ_WAIT,
      ST_RESP
   } state_type;

   typedef enum logic [2:0] {
      CUR_HOLD,
      CUR_ADVANCE,
      CUR_NEXT_ROW,
      CUR_COL0,
      CUR_HOME
   } cur_op_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_ZERO,
      CNT_INC
   } cnt_op_type;

   typedef enum logic [1:0] {
      WD_RESET,
      WD_BLANK,
      WD_CHAR,
      WD_RAM
   } wd_sel_type;

   typedef enum logic [1:0] {
      WA_COUNT,
      WA_CURSOR,
      WA_TARGET
   } wa_sel_type;

   typedef enum logic [1:0] {
      RA_TARGET,
      RA_SOURCE,
      RA_SCROLL,
      RA_SCROLL_NEXT
   } ra_sel_type;

   typedef struct packed {
      logic       ram_we;
      logic       ram_re;
      wd_sel_type wd_sel;
      wa_sel_type wa_sel;
      ra_sel_type ra_sel;
      cnt_op_type cnt_op;
      cur_op_type cur_op;
      logic       req_load;
      logic       rd_clear;
      logic       rd_capture;
      logic       rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            is_newline;
      logic            tgt_ok;
      logic            src_ok;
      logic            col_last;
      logic            row_last;
      logic            scroll_end;
      logic            fill_end;
      logic            rsp_free;
   } dp_sts_type;

endpackage

// ===== sv/tcce_ram.sv =====
// ----------------------------------------------------------------------------
// tcce_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tcce_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/tcce_dp.sv =====
// ----------------------------------------------------------------------------
// tcce_dp
// Datapath: request and cursor registers, sweep counter, cell store and
// result register.
// ----------------------------------------------------------------------------
module tcce_dp
   import tcce_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [COLOR_W-1:0]     csr_wdata,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [OP_W-1:0]        req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  dp_cmd_type             cmd,
   output dp_sts_type             sts
);

   localparam int CELLS        = COLUMNS * ROWS;
   localparam int SCROLL_CELLS = COLUMNS * (ROWS - 1);
   localparam int ADDR_W       = $clog2(CELLS);
   localparam int COL_LIM_W    = COL_W + 1;
   localparam int ROW_LIM_W    = ROW_W + 1;
   localparam logic [COL_LIM_W-1:0] COLS_LIM = COL_LIM_W'(COLUMNS);
   localparam logic [ROW_LIM_W-1:0] ROWS_LIM = ROW_LIM_W'(ROWS);
   localparam logic [COL_W-1:0]     COL_MAX  = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0]     ROW_MAX  = ROW_W'(ROWS - 1);
   localparam logic [ADDR_W-1:0]    FILL_LAST   = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0]    SCROLL_LAST = ADDR_W'(SCROLL_CELLS - 1);
   localparam logic [ADDR_W-1:0]    ROW_STEP    = ADDR_W'(COLUMNS);
   localparam logic [ADDR_W-1:0]    ROW_STEP1   = ADDR_W'(COLUMNS + 1);

   logic [COLOR_W-1:0] color_ff, color_in;
   logic [OP_W-1:0]    op_ff;
   logic [CHAR_W-1:0]  char_ff;
   logic [COL_W-1:0]   tc_ff, sc_ff;
   logic [ROW_W-1:0]   tr_ff, sr_ff;
   logic [ROW_W-1:0]   cur_row_ff, cur_row_in;
   logic [COL_W-1:0]   cur_col_ff, cur_col_in;
   logic [ADDR_W-1:0]  cnt_ff, cnt_in;
   logic [ENTRY_W-1:0] rd_ff, rd_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]   rsp_row_ff;
   logic [COL_W-1:0]   rsp_col_ff;
   logic [ENTRY_W-1:0] rsp_data_ff;

   logic [ADDR_W-1:0]  cursor_addr, target_addr, source_addr;
   logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
   logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

   // config register
   assign csr_ready = 1'b1;
   assign color_in  = csr_valid ? csr_wdata : color_ff;

   // cell addresses: row * COLUMNS + col
   assign cursor_addr = ADDR_W'(cur_row_ff) * ROW_STEP + ADDR_W'(cur_col_ff);
   assign target_addr = ADDR_W'(tr_ff) * ROW_STEP + ADDR_W'(tc_ff);
   assign source_addr = ADDR_W'(sr_ff) * ROW_STEP + ADDR_W'(sc_ff);

   always_comb begin
      case (cmd.wa_sel)
         WA_CURSOR: ram_waddr = cursor_addr;
         WA_TARGET: ram_waddr = target_addr;
         default:   ram_waddr = cnt_ff;
      endcase
      case (cmd.ra_sel)
         RA_SOURCE:      ram_raddr = source_addr;
         RA_SCROLL:      ram_raddr = cnt_ff + ROW_STEP;
         RA_SCROLL_NEXT: ram_raddr = cnt_ff + ROW_STEP1;
         default:        ram_raddr = target_addr;
      endcase
      case (cmd.wd_sel)
         WD_BLANK: ram_wdata = {color_ff, BLANK_CHAR};
         WD_CHAR:  ram_wdata = {color_ff, char_ff};
         WD_RAM:   ram_wdata = ram_rdata;
         default:  ram_wdata = RESET_ENTRY;
      endcase
   end

   tcce_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CELLS)
   ) u_store (
      .clock (clock),
      .we    (cmd.ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (cmd.ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // cursor update
   always_comb begin
      cur_row_in = cur_row_ff;
      cur_col_in = cur_col_ff;
      case (cmd.cur_op)
         CUR_ADVANCE: cur_col_in = cur_col_ff + 1'b1;
         CUR_NEXT_ROW: begin
            cur_row_in = cur_row_ff + 1'b1;
            cur_col_in = '0;
         end
         CUR_COL0: cur_col_in = '0;
         CUR_HOME: begin
            cur_row_in = '0;
            cur_col_in = '0;
         end
         default: ;
      endcase
   end

   always_comb begin
      case (cmd.cnt_op)
         CNT_ZERO: cnt_in = '0;
         CNT_INC:  cnt_in = cnt_ff + 1'b1;
         default:  cnt_in = cnt_ff;
      endcase
   end

   always_comb begin
      rd_in = rd_ff;
      if (cmd.rd_clear) begin
         rd_in = '0;
      end else if (cmd.rd_capture) begin
         rd_in = ram_rdata;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff     <= RESET_COLOR;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         color_ff     <= color_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= rd_in;
      if (cmd.req_load) begin
         op_ff   <= req_tuser;
         char_ff <= req_tdata[7:0];
         tc_ff   <= req_tdata[14:8];
         tr_ff   <= req_tdata[19:15];
         sc_ff   <= req_tdata[26:20];
         sr_ff   <= req_tdata[31:27];
      end
      if (cmd.rsp_load) begin
         rsp_row_ff  <= cur_row_ff;
         rsp_col_ff  <= cur_col_ff;
         rsp_data_ff <= rd_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_data_ff, rsp_col_ff, rsp_row_ff};

   // status
   assign sts.op         = op_ff;
   assign sts.is_newline = (char_ff == NEWLINE_CHAR);
   assign sts.tgt_ok     = ({1'b0, tc_ff} < COLS_LIM) && ({1'b0, tr_ff} < ROWS_LIM);
   assign sts.src_ok     = ({1'b0, sc_ff} < COLS_LIM) && ({1'b0, sr_ff} < ROWS_LIM);
   assign sts.col_last   = (cur_col_ff == COL_MAX);
   assign sts.row_last   = (cur_row_ff == ROW_MAX);
   assign sts.scroll_end = (cnt_ff == SCROLL_LAST);
   assign sts.fill_end   = (cnt_ff == FILL_LAST);
   assign sts.rsp_free   = !rsp_valid_ff || rsp_tready;

endmodule

// ===== sv/tcce_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcce_ctrl
// Controller: sequences store sweeps, cell accesses and the result handoff.
// ----------------------------------------------------------------------------
module tcce_ctrl
   import tcce_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (sts.fill_end) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            case (sts.op)
               OP_PUT_CHAR: begin
                  if (sts.row_last && (sts.is_newline || sts.col_last)) begin
                     state_in = ST_SCROLL_PRIME;
                  end else begin
                     state_in = ST_RESP;
                  end
               end
               OP_CLEAR: state_in = ST_FILL;
               OP_COPY:  state_in = (sts.tgt_ok && sts.src_ok) ? ST_COPY_WR : ST_RESP;
               OP_READ:  state_in = sts.tgt_ok ? ST_READ_WAIT : ST_RESP;
               default:  state_in = ST_RESP;
            endcase
         end
         ST_SCROLL_PRIME: state_in = ST_SCROLL;
         ST_SCROLL: begin
            if (sts.scroll_end) state_in = ST_FILL;
         end
         ST_FILL: begin
            if (sts.fill_end) state_in = ST_RESP;
         end
         ST_COPY_WR:   state_in = ST_RESP;
         ST_READ_WAIT: state_in = ST_RESP;
         ST_RESP: begin
            if (sts.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_INIT;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      cmd.wd_sel = WD_RESET;
      cmd.wa_sel = WA_COUNT;
      cmd.ra_sel = RA_TARGET;
      cmd.cnt_op = CNT_HOLD;
      cmd.cur_op = CUR_HOLD;
      req_tready = 1'b0;
      case (state_ff)
         ST_INIT: begin
            cmd.ram_we = 1'b1;
            cmd.cnt_op = CNT_INC;
         end
         ST_IDLE: begin
            req_tready   = 1'b1;
            cmd.req_load = req_tvalid;
         end
         ST_EXEC: begin
            cmd.rd_clear = 1'b1;
            case (sts.op)
               OP_PUT_CHAR: begin
                  if (!sts.is_newline) begin
                     cmd.ram_we = 1'b1;
                     cmd.wd_sel = WD_CHAR;
                     cmd.wa_sel = WA_CURSOR;
                  end
                  if (!sts.is_newline && !sts.col_last) begin
                     cmd.cur_op = CUR_ADVANCE;
                  end else if (!sts.row_last) begin
                     cmd.cur_op = CUR_NEXT_ROW;
                  end else begin
                     cmd.cur_op = CUR_COL0;
                     cmd.cnt_op = CNT_ZERO;
                  end
               end
               OP_CLEAR: begin
                  cmd.cur_op = CUR_HOME;
                  cmd.cnt_op = CNT_ZERO;
               end
               OP_WRITE: begin
                  cmd.ram_we = sts.tgt_ok;
                  cmd.wd_sel = WD_CHAR;
                  cmd.wa_sel = WA_TARGET;
               end
               OP_COPY: begin
                  cmd.ram_re = sts.tgt_ok && sts.src_ok;
                  cmd.ra_sel = RA_SOURCE;
               end
               OP_READ: begin
                  cmd.ram_re = sts.tgt_ok;
                  cmd.ra_sel = RA_TARGET;
               end
               default: ;
            endcase
         end
         ST_SCROLL_PRIME: begin
            cmd.ram_re = 1'b1;
            cmd.ra_sel = RA_SCROLL;
         end
         ST_SCROLL: begin
            cmd.ram_we = 1'b1;
            cmd.wd_sel = WD_RAM;
            cmd.cnt_op = CNT_INC;
            cmd.ram_re = !sts.scroll_end;
            cmd.ra_sel = RA_SCROLL_NEXT;
         end
         ST_FILL: begin
            cmd.ram_we = 1'b1;
            cmd.wd_sel = WD_BLANK;
            cmd.cnt_op = CNT_INC;
         end
         ST_COPY_WR: begin
            cmd.ram_we = 1'b1;
            cmd.wd_sel = WD_RAM;
            cmd.wa_sel = WA_TARGET;
         end
         ST_READ_WAIT: cmd.rd_capture = 1'b1;
         ST_RESP:      cmd.rsp_load   = sts.rsp_free;
         default: ;
      endcase
   end

endmodule

// ===== sv/text_console_char_engine_top.sv =====
// ----------------------------------------------------------------------------
// text_console_char_engine_top
// Text console engine: character cell store with cursor, scroll and clear.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: one item per request. req_tuser holds the opcode (put char,
//    clear, write cell, copy cell, read cell); req_tdata holds the operands.
//  - rsp channel: exactly one item per request, in order: cursor row and
//    column after the request, plus the cell read by a read request (else 0).
//  - csr channel: writes the attribute byte used for every cell write. It is
//    always ready; write it only while no request is outstanding.
//  - One request is in work at a time; clear and a put char that scrolls
//    take longest, since each sweeps the whole store. The store has one
//    write and one registered read port, so scroll and clear walk it one
//    cell per cycle.
//  - After reset the store is filled with blank grey cells, one per cycle;
//    req_tready stays low until the fill is done.
//  - The result sits in an output register: the next request is accepted
//    while it waits, but a second result is held back until it is taken.
// ----------------------------------------------------------------------------
module text_console_char_engine_top
   import tcce_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                   clock,
   input  logic                   reset,
   // config: text_color
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [COLOR_W-1:0]     csr_wdata,   // text_color
   // requests
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // char_code[7:0], target_col[14:8], target_row[19:15],
   // source_col[26:20], source_row[31:27]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [OP_W-1:0]        req_tuser,   // opcode[2:0]
   // results
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // out_row[4:0], out_col[11:5], read_data[27:12], zero[31:28]
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   // sequencer: owns the request handshake and every datapath command
   tcce_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // store, cursor, operand and result registers
   tcce_dp #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------

   // the fill after reset blocks requests
   a_reset_fill: assert property (@(posedge clock) reset |=> !req_tready)
      else $error("request accepted during reset fill");

   // one request in work at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request accepted while one is in work");

   // reported cursor always lies on the screen
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ({1'b0, rsp_tdata[4:0]} < 6'(ROWS)) &&
                     ({1'b0, rsp_tdata[11:5]} < 8'(COLUMNS)))
      else $error("cursor off screen");

   // a result load never overlaps a store write, such as a sweep, or a request load
   a_no_load_in_sweep: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !cmd.ram_we && !cmd.req_load)
      else $error("result loaded during a store access");

endmodule

// ===== tb/sv/text_console_char_engine_top_test.sv =====
// ----------------------------------------------------------------------------
// text_console_char_engine_top_test
// Self-checking bench for the text console character engine.
// A directed table walks the corner cases: reset contents, unsigned bytes,
// newline, wrap, scroll at the last row and at the last cell, clear,
// off-screen cells and spare opcodes. Random text streams with cell writes,
// copies and reads follow. The attribute byte changes between phases.
// Each result is checked against its typed reply or a cycle-free mirror of
// the cell store and cursor. Both sides idle at random, and the result side
// holds off once for a long stretch.
// ----------------------------------------------------------------------------
module text_console_char_engine_top_test
   import tcce_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SCREEN_COLS  = 80;
   localparam int SCREEN_ROWS  = 25;
   localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;
   localparam int PHASES       = 5;
   localparam int PHASE_ITEMS  = 145;
   localparam int LONG_HOLD    = 400;   // cycles the result side stays off

   // spare opcodes: the engine only reports the cursor
   localparam logic [OP_W-1:0] OP_SPARE_LO  = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_HI  = 3'd7;

   // request operands, LSB first: char, target col/row, source col/row
   typedef struct packed {
      logic [ROW_W-1:0]  src_row;
      logic [COL_W-1:0]  src_col;
      logic [ROW_W-1:0]  dst_row;
      logic [COL_W-1:0]  dst_col;
      logic [CHAR_W-1:0] ch;
   } req_fields_type;

   // result, LSB first: cursor row, cursor col, read data, zero pad
   typedef struct packed {
      logic [RSP_PAD_W-1:0] pad;
      logic [ENTRY_W-1:0]   rd;
      logic [COL_W-1:0]     col;
      logic [ROW_W-1:0]     row;
   } reply_type;

   // one line of the directed table
   typedef struct {
      logic [OP_W-1:0] op;
      req_fields_type  fields;
      int              reps;
      bit              typed;   // reply typed in by hand
      reply_type       want;
   } console_step_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [COLOR_W-1:0]     csr_wdata;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [OP_W-1:0]        req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // mirror of the engine: cell store, cursor and attribute byte
   logic [ENTRY_W-1:0] screen_mirror [SCREEN_CELLS];
   logic [ROW_W-1:0]   mirror_row;
   logic [COL_W-1:0]   mirror_col;
   logic [COLOR_W-1:0] mirror_color;

   reply_type        pending_replies [$];
   console_step_type directed_steps [$];

   int  mismatch_count  = 0;
   int  accepted_count  = 0;
   int  reply_count     = 0;
   int  scroll_count    = 0;
   int  clear_count     = 0;
   int  read_count      = 0;
   int  offscreen_count = 0;
   int  color_writes    = 0;
   int  stall_left      = 0;
   bit  quiet_phase     = 1'b0;   // no idling on either side
   bit  long_hold_req   = 1'b0;   // ask the result side for one long hold-off
   reply_type seen_reply;
   reply_type wanted_reply;

   text_console_char_engine_top #(
      .COLUMNS (SCREEN_COLS),
      .ROWS    (SCREEN_ROWS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop; a correct run needs a small fraction of this
   initial begin
      #100_000_000;
      $display("Verification failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Mirror of the engine
   // ------------------------------------------------------------------------
   function automatic logic [ENTRY_W-1:0] colored(input logic [CHAR_W-1:0] c);
      return {mirror_color, c};
   endfunction

   function automatic bit on_screen(input logic [COL_W-1:0] c, input logic [ROW_W-1:0] r);
      return (c < SCREEN_COLS) && (r < SCREEN_ROWS);
   endfunction

   function automatic int cell_at(input logic [COL_W-1:0] c, input logic [ROW_W-1:0] r);
      return int'(r) * SCREEN_COLS + int'(c);
   endfunction

   // every row moves up one, the bottom row goes blank in the current color, column 0
   function automatic void scroll_mirror();
      for (int i = 0; i < SCREEN_COLS * (SCREEN_ROWS - 1); i++)
         screen_mirror[i] = screen_mirror[i + SCREEN_COLS];
      for (int i = SCREEN_COLS * (SCREEN_ROWS - 1); i < SCREEN_CELLS; i++)
         screen_mirror[i] = colored(BLANK_CHAR);
      mirror_col = '0;
      scroll_count++;
   endfunction

   function automatic void line_feed();
      if (mirror_row < SCREEN_ROWS - 1) begin
         mirror_row++;
         mirror_col = '0;
      end else begin
         scroll_mirror();
      end
   endfunction

   function automatic reply_type predict_reply(input logic [OP_W-1:0] op,
                                               input req_fields_type f);
      reply_type r;
      r = '0;
      case (op)
         OP_PUT_CHAR: begin
            if (f.ch == NEWLINE_CHAR) begin
               line_feed();
            end else begin
               if (on_screen(mirror_col, mirror_row))
                  screen_mirror[cell_at(mirror_col, mirror_row)] = colored(f.ch);
               if (mirror_col < SCREEN_COLS - 1)
                  mirror_col++;
               else
                  line_feed();
            end
         end
         OP_CLEAR: begin
            for (int i = 0; i < SCREEN_CELLS; i++)
               screen_mirror[i] = colored(BLANK_CHAR);
            mirror_row = '0;
            mirror_col = '0;
            clear_count++;
         end
         OP_WRITE: begin
            if (on_screen(f.dst_col, f.dst_row))
               screen_mirror[cell_at(f.dst_col, f.dst_row)] = colored(f.ch);
            else
               offscreen_count++;
         end
         OP_COPY: begin
            if (on_screen(f.dst_col, f.dst_row) && on_screen(f.src_col, f.src_row))
               screen_mirror[cell_at(f.dst_col, f.dst_row)] =
                  screen_mirror[cell_at(f.src_col, f.src_row)];
            else
               offscreen_count++;
         end
         OP_READ: begin
            read_count++;
            if (on_screen(f.dst_col, f.dst_row))
               r.rd = screen_mirror[cell_at(f.dst_col, f.dst_row)];
            else
               offscreen_count++;
         end
         default: ;
      endcase
      r.row = mirror_row;
      r.col = mirror_col;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (quiet_phase || p < 60) return 0;
      if (p < 90) return $urandom_range(1, 3);
      if (p < 98) return $urandom_range(4, 12);
      return $urandom_range(30, 80);
   endfunction

   task automatic add_step(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                           input int tc, input int tr, input int sc, input int sr,
                           input int reps, input bit typed,
                           input int e_row, input int e_col, input int e_rd);
      console_step_type s;
      s.op             = op;
      s.fields.ch      = ch;
      s.fields.dst_col = COL_W'(tc);
      s.fields.dst_row = ROW_W'(tr);
      s.fields.src_col = COL_W'(sc);
      s.fields.src_row = ROW_W'(sr);
      s.reps           = reps;
      s.typed          = typed;
      s.want           = '0;
      s.want.row       = ROW_W'(e_row);
      s.want.col       = COL_W'(e_col);
      s.want.rd        = ENTRY_W'(e_rd);
      directed_steps.push_back(s);
   endtask

   // Offer one item; valid stays high on return so the next item can follow
   // back to back. The mirror is advanced in accept order.
   task automatic offer_request(input logic [OP_W-1:0] op, input req_fields_type f,
                                input int gap, input bit typed,
                                input reply_type typed_reply);
      reply_type predicted;
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= f;
      do @(posedge clock); while (!req_tready);
      predicted = predict_reply(op, f);
      pending_replies.push_back(typed ? typed_reply : predicted);
      accepted_count++;
   endtask

   // drop valid and wait for every outstanding result
   task automatic settle_console();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // Aim at a cell: mostly on screen, often the cursor row or the one above
   // where text was just written, now and then anywhere in the field range.
   task automatic aim_cell(output logic [COL_W-1:0] c, output logic [ROW_W-1:0] r);
      int p;
      p = $urandom_range(0, 99);
      if (p < 12) begin
         c = COL_W'($urandom_range(0, (1 << COL_W) - 1));
         r = ROW_W'($urandom_range(0, (1 << ROW_W) - 1));
      end else if (p < 55) begin
         c = COL_W'($urandom_range(0, SCREEN_COLS - 1));
         r = (mirror_row > 0 && $urandom_range(0, 1)) ? mirror_row - 1'b1 : mirror_row;
      end else begin
         c = COL_W'($urandom_range(0, SCREEN_COLS - 1));
         r = ROW_W'($urandom_range(0, SCREEN_ROWS - 1));
      end
   endtask

   // Text-heavy mix: put char dominates so the cursor walks down, wraps and
   // scrolls; clear is rare since it walks the whole store.
   task automatic make_random_request(output logic [OP_W-1:0] op,
                                      output req_fields_type f);
      int p;
      logic [COL_W-1:0] c;
      logic [ROW_W-1:0] r;
      f = req_fields_type'($urandom);
      p = $urandom_range(0, 99);
      if (p < 55) begin
         op = OP_PUT_CHAR;
         if ($urandom_range(0, 99) < 12) f.ch = NEWLINE_CHAR;
      end else if (p < 57) begin
         op = OP_CLEAR;
      end else if (p < 69) begin
         op = OP_WRITE;
      end else if (p < 81) begin
         op = OP_COPY;
      end else if (p < 95) begin
         op = OP_READ;
      end else begin
         case ($urandom_range(0, 2))
            0:       op = OP_SPARE_LO;
            1:       op = OP_SPARE_MID;
            default: op = OP_SPARE_HI;
         endcase
      end
      if (op != OP_PUT_CHAR && op != OP_CLEAR) begin
         aim_cell(c, r);
         f.dst_col = c;
         f.dst_row = r;
         aim_cell(c, r);
         f.src_col = c;
         f.src_row = r;
      end
   endtask

   // ------------------------------------------------------------------------
   // Result side: random stalls, plus one long hold-off on request. The hold
   // is counted here while the sender keeps offering, so the output register
   // fills and the engine stops taking items.
   // ------------------------------------------------------------------------
   initial begin
      forever begin
         @(negedge clock);
         if (stall_left == 0) begin
            if (long_hold_req) begin
               long_hold_req = 1'b0;
               stall_left    = LONG_HOLD;
            end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
               stall_left = pick_gap();
            end
         end
         rsp_tready <= (stall_left == 0);
         if (stall_left > 0) stall_left--;
      end
   end

   // ------------------------------------------------------------------------
   // Checker: each taken result against the oldest expectation
   // ------------------------------------------------------------------------
   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_reply = rsp_tdata;
         reply_count++;
         if (pending_replies.size() == 0) begin
            $display("%0t: result %0h with nothing expected", $time, rsp_tdata);
            mismatch_count++;
         end else begin
            wanted_reply = pending_replies.pop_front();
            check_field("out_row",   wanted_reply.row, seen_reply.row);
            check_field("out_col",   wanted_reply.col, seen_reply.col);
            check_field("read_data", wanted_reply.rd,  seen_reply.rd);
            check_field("pad",       wanted_reply.pad, seen_reply.pad);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      logic [OP_W-1:0]    rnd_op;
      req_fields_type     rnd_fields;
      logic [COLOR_W-1:0] phase_color;

      // all inputs known from time zero
      reset      = 1'b1;
      csr_valid  = 1'b0;
      csr_wdata  = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_PUT_CHAR;
      rsp_tready = 1'b0;

      // mirror at reset: blank grey store, cursor home
      for (int i = 0; i < SCREEN_CELLS; i++) screen_mirror[i] = RESET_ENTRY;
      mirror_row   = '0;
      mirror_col   = '0;
      mirror_color = RESET_COLOR;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // the engine blanks its store after reset; req_tready covers that wait

      // Directed table, reset attribute byte. Rows with reps > 1 and rows
      // without a typed reply are checked against the mirror.
      //        op           ch            tc   tr  sc   sr  reps typed row col rd
      add_step(OP_READ,     8'h00,         0,  0,   0,  0,  1,  1,  0,  0, 16'h0720);
      add_step(OP_READ,     8'h00,        79, 24,   0,  0,  1,  1,  0,  0, 16'h0720);
      add_step(OP_READ,     8'h00,        80,  0,   0,  0,  1,  1,  0,  0, 16'h0000);
      add_step(OP_READ,     8'h00,       127, 31, 127, 31,  1,  1,  0,  0, 16'h0000);
      add_step(OP_PUT_CHAR, 8'h41,         0,  0,   0,  0,  1,  1,  0,  1, 16'h0000);
      add_step(OP_PUT_CHAR, 8'h00,         0,  0,   0,  0,  1,  1,  0,  2, 16'h0000);
      // top bit set: the byte must not smear into the attribute
      add_step(OP_PUT_CHAR, 8'hFF,         0,  0,   0,  0,  1,  1,  0,  3, 16'h0000);
      add_step(OP_READ,     8'h00,         2,  0,   0,  0,  1,  1,  0,  3, 16'h07FF);
      add_step(OP_PUT_CHAR, NEWLINE_CHAR,  0,  0,   0,  0,  1,  1,  1,  0, 16'h0000);
      add_step(OP_WRITE,    8'h5A,        79,  0,   0,  0,  1,  1,  1,  0, 16'h0000);
      add_step(OP_WRITE,    8'h5B,        80,  0,   0,  0,  1,  1,  1,  0, 16'h0000);
      add_step(OP_WRITE,    8'h5C,         0, 25,   0,  0,  1,  1,  1,  0, 16'h0000);
      add_step(OP_COPY,     8'h00,         0, 24,  79,  0,  1,  1,  1,  0, 16'h0000);
      add_step(OP_COPY,     8'h00,         1,  1,  80,  0,  1,  1,  1,  0, 16'h0000);
      add_step(OP_COPY,     8'h00,         0, 31,   0,  0,  1,  1,  1,  0, 16'h0000);
      add_step(OP_READ,     8'h00,         0, 24,   0,  0,  1,  1,  1,  0, 16'h075A);
      add_step(OP_READ,     8'h00,         1,  1,   0,  0,  1,  1,  1,  0, 16'h0720);
      add_step(OP_SPARE_LO, 8'h00,         0,  0,   0,  0,  1,  1,  1,  0, 16'h0000);
      add_step(OP_SPARE_HI, 8'hFF,       127, 31, 127, 31,  1,  1,  1,  0, 16'h0000);
      // walk down to the last row, then scroll on a newline
      add_step(OP_PUT_CHAR, NEWLINE_CHAR,  0,  0,   0,  0, 23,  0,  0,  0, 0);
      add_step(OP_PUT_CHAR, NEWLINE_CHAR,  0,  0,   0,  0,  1,  1, 24,  0, 16'h0000);
      add_step(OP_READ,     8'h00,         0, 23,   0,  0,  1,  1, 24,  0, 16'h075A);
      // fill the last row; the char in the last cell wraps and scrolls
      add_step(OP_PUT_CHAR, 8'h78,         0,  0,   0,  0, 79,  0,  0,  0, 0);
      add_step(OP_PUT_CHAR, 8'h7A,         0,  0,   0,  0,  1,  1, 24,  0, 16'h0000);
      add_step(OP_READ,     8'h00,        79, 23,   0,  0,  1,  1, 24,  0, 16'h077A);
      add_step(OP_READ,     8'h00,        78, 24,   0,  0,  1,  1, 24,  0, 16'h0720);
      add_step(OP_SPARE_MID, 8'h00,        0,  0,   0,  0,  1,  1, 24,  0, 16'h0000);
      add_step(OP_CLEAR,    8'h00,         0,  0,   0,  0,  1,  1,  0,  0, 16'h0000);
      add_step(OP_READ,     8'h00,        79, 24,   0,  0,  1,  1,  0,  0, 16'h0720);

      foreach (directed_steps[i]) begin
         for (int k = 0; k < directed_steps[i].reps; k++)
            offer_request(directed_steps[i].op, directed_steps[i].fields, pick_gap(),
                          directed_steps[i].typed, directed_steps[i].want);
      end

      // Random phases. The engine is drained before each attribute write,
      // which is also the sender's full pause until every result is back.
      for (int phase = 0; phase < PHASES; phase++) begin
         settle_console();
         case (phase)
            0:       phase_color = '0;
            1:       phase_color = '1;
            3:       phase_color = 8'h1E;
            default: phase_color = COLOR_W'($urandom_range(0, (1 << COLOR_W) - 1));
         endcase
         quiet_phase = (phase == 2);
         @(negedge clock);
         csr_valid <= 1'b1;
         csr_wdata <= phase_color;
         do @(posedge clock); while (!csr_ready);
         mirror_color = phase_color;
         color_writes++;
         @(negedge clock);
         csr_valid <= 1'b0;

         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (phase == 3 && k == 40) long_hold_req = 1'b1;
            make_random_request(rnd_op, rnd_fields);
            offer_request(rnd_op, rnd_fields, pick_gap(), 1'b0, '0);
         end
      end

      settle_console();
      repeat (20) @(posedge clock);

      $display("Run: %0d requests, %0d results, %0d reads, %0d off-screen cells",
               accepted_count, reply_count, read_count, offscreen_count);
      $display("     %0d scrolls, %0d clears, %0d attribute writes",
               scroll_count, clear_count, color_writes);
      if (mismatch_count == 0 && pending_replies.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== text_console_char_engine_top.f =====
sv/tcce_pkg.sv
sv/tcce_ram.sv
sv/tcce_dp.sv
sv/tcce_ctrl.sv
sv/text_console_char_engine_top.sv
tb/sv/text_console_char_engine_top_test.sv
